@@ design/imadec_pkg.sv @@
package imadec_pkg;

   localparam logic [11:0] MAX_BLOCK_SAMPLES = 12'd4089;
   localparam logic [6:0]  MAX_STEP_INDEX    = 7'd88;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 12;

   localparam logic [CSR_IDX_W-1:0] CSR_MULAW_OUTPUT      = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLES_PER_BLOCK = 1'b1;

   typedef enum logic [2:0] {
      HDR_IDLE,
      HDR_SAMPLE_HI,
      HDR_INDEX,
      HDR_SPARE,
      HDR_DATA
   } hdr_state_type;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               last;
   } result_type;

   // standard IMA step sizes, 89 entries
   function automatic logic [14:0] step_of(input logic [6:0] idx);
      logic [14:0] s;
      case (idx)
         7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
         7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
         7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
         7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
         7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
         7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
         7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
         7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
         7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
         7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
         7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
         7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
         7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
         7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
         7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
         7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
         7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
         7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
         7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
         7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
         7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
         7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
         7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
         7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
         7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
         7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
         7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
         7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
         7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
         7'd87: s = 15'd29794;
         default: s = 15'd32767;
      endcase
      return s;
   endfunction

   function automatic logic signed [4:0] index_adjust(input logic [2:0] mag);
      logic signed [4:0] a;
      case (mag)
         3'd4:    a = 5'sd2;
         3'd5:    a = 5'sd4;
         3'd6:    a = 5'sd6;
         3'd7:    a = 5'sd8;
         default: a = -5'sd1;
      endcase
      return a;
   endfunction

endpackage

@@ design/imadec_nibble.sv @@
module imadec_nibble (
   input  logic signed [15:0] pred,
   input  logic [6:0]         idx,
   input  logic [3:0]         code,
   output logic signed [15:0] pred_out,
   output logic [6:0]         idx_out
);
   import imadec_pkg::*;

   logic [14:0]        step;
   logic [16:0]        diff;
   logic signed [17:0] sum;
   logic signed [4:0]  adj;
   logic signed [7:0]  ni;

   always_comb begin
      step = step_of(idx);
      diff = {5'd0, step[14:3]};
      if (code[2]) diff = diff + {2'd0, step};
      if (code[1]) diff = diff + {3'd0, step[14:1]};
      if (code[0]) diff = diff + {4'd0, step[14:2]};

      if (code[3]) sum = {{2{pred[15]}}, pred} - $signed({1'b0, diff});
      else         sum = {{2{pred[15]}}, pred} + $signed({1'b0, diff});

      if (sum < -18'sd32768)     pred_out = 16'sh8000;
      else if (sum > 18'sd32767) pred_out = 16'sh7FFF;
      else                       pred_out = sum[15:0];

      adj = index_adjust(code[2:0]);
      ni  = $signed({1'b0, idx}) + {{3{adj[4]}}, adj};
      if (ni < 8'sd0)                           idx_out = 7'd0;
      else if (ni > $signed({1'b0, MAX_STEP_INDEX})) idx_out = MAX_STEP_INDEX;
      else                                      idx_out = ni[6:0];
   end

endmodule

@@ design/imadec_mulaw.sv @@
module imadec_mulaw (
   input  logic signed [15:0] x,
   output logic [7:0]         code
);
   logic [14:0] mag;
   logic [13:0] biased;
   logic [12:0] clipped;
   logic [12:0] shifted;
   logic [3:0]  seg;
   logic [3:0]  seg_inv;

   always_comb begin
      mag     = x[15] ? ~x[14:0] : x[14:0];
      biased  = {1'b0, mag[14:2]} + 14'd33;
      clipped = biased[13] ? 13'h1FFF : biased[12:0];
      // segment = 1 + bit length of the top seven bits
      seg = 4'd1;
      for (int i = 0; i < 7; i++) begin
         if (clipped[6+i]) seg = 4'(i + 2);
      end
      shifted = clipped >> seg;
      seg_inv = 4'd8 - seg;
      code    = {~x[15], seg_inv[2:0], ~shifted[3:0]};
   end

endmodule

@@ design/imadec_outbuf.sv @@
module imadec_outbuf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  logic [1:0]             load_count,
   input  imadec_pkg::result_type load_res0,
   input  imadec_pkg::result_type load_res1,
   input  logic                   mulaw_mode,
   output logic                   free,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [15:0]     rsp_sample,
   output logic [7:0]             rsp_mulaw_code,
   output logic                   rsp_last_of_block
);
   import imadec_pkg::*;

   result_type entry_ff [2];
   logic [1:0] count_ff;
   logic       ptr_ff;
   result_type cur;
   logic [7:0] code;

   assign cur       = entry_ff[ptr_ff];
   assign rsp_valid = (count_ff != 2'd0);
   // empty now, or the last word leaves this cycle
   assign free      = (count_ff == 2'd0) || (count_ff == 2'd1 && rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         ptr_ff   <= 1'b0;
      end else if (load) begin
         count_ff <= load_count;
         ptr_ff   <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         count_ff <= count_ff - 2'd1;
         ptr_ff   <= ~ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         entry_ff[0] <= load_res0;
         entry_ff[1] <= load_res1;
      end
   end

   imadec_mulaw u_mulaw (
      .x    (cur.sample),
      .code (code)
   );

   assign rsp_sample        = cur.sample;
   assign rsp_last_of_block = cur.last;
   assign rsp_mulaw_code    = mulaw_mode ? code : 8'd0;

endmodule

@@ design/ima_adpcm_block_decoder.sv @@
// A word accepted on req_ is held in the input register, then decoded into the
//   two-entry result buffer, whose head drives rsp_.
// Header bytes go one byte per cycle while the result buffer is free; a data byte
//   yields up to two samples, and the next byte waits until its last sample leaves.
// Reset (synchronous, active high): decoder idle, predictor/index/count cleared,
//   mulaw_output = 0, samples_per_block = 505, no result pending.
module ima_adpcm_block_decoder (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [imadec_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [imadec_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [7:0]                           req_data_byte,
   input  logic                                 req_block_start,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [15:0]                   rsp_sample,
   output logic [7:0]                           rsp_mulaw_code,
   output logic                                 rsp_last_of_block
);
   import imadec_pkg::*;

   // configuration registers
   logic        mulaw_ff;
   logic [11:0] spb_ff;

   // input register
   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_start_ff;

   // decoder state
   hdr_state_type      hdr_ff, hdr_in;
   logic signed [15:0] pred_ff, pred_in;
   logic [6:0]         idx_ff, idx_in;
   logic [7:0]         low_ff, low_in;
   logic [11:0]        left_ff, left_in;

   // decode results headed for the buffer
   logic [1:0]  ld_count;
   result_type  ld_res0, ld_res1;
   logic        buf_free;
   logic        advance;

   logic signed [15:0] n0_pred, n1_pred;
   logic [6:0]         n0_idx, n1_idx;
   logic [11:0]        total;
   logic [11:0]        left_m1, left_m2;

   // the input register moves into decode whenever the buffer can take its words
   assign advance   = in_valid_ff && buf_free;
   assign req_ready = !in_valid_ff || buf_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         mulaw_ff <= 1'b0;
         spb_ff   <= 12'd505;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MULAW_OUTPUT:      mulaw_ff <= csr_wdata[0];
            CSR_SAMPLES_PER_BLOCK: spb_ff   <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_byte_ff  <= req_data_byte;
         in_start_ff <= req_block_start;
      end
   end

   // two chained nibble updates, low nibble first
   imadec_nibble u_nib0 (
      .pred     (pred_ff),
      .idx      (idx_ff),
      .code     (in_byte_ff[3:0]),
      .pred_out (n0_pred),
      .idx_out  (n0_idx)
   );

   imadec_nibble u_nib1 (
      .pred     (n0_pred),
      .idx      (n0_idx),
      .code     (in_byte_ff[7:4]),
      .pred_out (n1_pred),
      .idx_out  (n1_idx)
   );

   assign left_m1 = left_ff - 12'd1;
   assign left_m2 = left_ff - 12'd2;

   always_comb begin
      if (spb_ff > MAX_BLOCK_SAMPLES) total = MAX_BLOCK_SAMPLES;
      else if (spb_ff == 12'd0)       total = 12'd1;
      else                            total = spb_ff;
   end

   always_comb begin
      hdr_in   = hdr_ff;
      pred_in  = pred_ff;
      idx_in   = idx_ff;
      low_in   = low_ff;
      left_in  = left_ff;
      ld_count = 2'd0;
      ld_res0  = '{sample: n0_pred, last: (left_m1 == 12'd0)};
      ld_res1  = '{sample: n1_pred, last: (left_m2 == 12'd0)};
      if (in_start_ff) begin
         // block start always restarts the header
         low_in = in_byte_ff;
         hdr_in = HDR_SAMPLE_HI;
      end else begin
         case (hdr_ff)
            HDR_SAMPLE_HI: begin
               pred_in  = {in_byte_ff, low_ff};
               left_in  = total - 12'd1;
               ld_res0  = '{sample: {in_byte_ff, low_ff}, last: (total == 12'd1)};
               ld_count = 2'd1;
               hdr_in   = HDR_INDEX;
            end
            HDR_INDEX: begin
               idx_in = (in_byte_ff > {1'b0, MAX_STEP_INDEX}) ? MAX_STEP_INDEX
                                                              : in_byte_ff[6:0];
               hdr_in = HDR_SPARE;
            end
            HDR_SPARE: begin
               hdr_in = HDR_DATA;
            end
            HDR_DATA: begin
               if (left_ff == 12'd0) begin
                  hdr_in = HDR_IDLE;
               end else if (left_m1 == 12'd0) begin
                  // last sample is the low nibble; high nibble dropped
                  pred_in  = n0_pred;
                  idx_in   = n0_idx;
                  left_in  = left_m1;
                  ld_count = 2'd1;
                  hdr_in   = HDR_IDLE;
               end else begin
                  pred_in  = n1_pred;
                  idx_in   = n1_idx;
                  left_in  = left_m2;
                  ld_count = 2'd2;
                  if (left_m2 == 12'd0) hdr_in = HDR_IDLE;
               end
            end
            default: begin
               hdr_in = HDR_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff  <= HDR_IDLE;
         pred_ff <= 16'sd0;
         idx_ff  <= 7'd0;
         low_ff  <= 8'd0;
         left_ff <= 12'd0;
      end else if (advance) begin
         hdr_ff  <= hdr_in;
         pred_ff <= pred_in;
         idx_ff  <= idx_in;
         low_ff  <= low_in;
         left_ff <= left_in;
      end
   end

   imadec_outbuf u_outbuf (
      .clock             (clock),
      .reset             (reset),
      .load              (advance),
      .load_count        (ld_count),
      .load_res0         (ld_res0),
      .load_res1         (ld_res1),
      .mulaw_mode        (mulaw_ff),
      .free              (buf_free),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_sample        (rsp_sample),
      .rsp_mulaw_code    (rsp_mulaw_code),
      .rsp_last_of_block (rsp_last_of_block)
   );

   // step index never leaves the table
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= MAX_STEP_INDEX)
      else $error("step index out of range");

   // idle decoder has no samples outstanding
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (hdr_ff == HDR_IDLE) |-> (left_ff == 12'd0))
      else $error("idle with samples left");

   // sample count only grows when the header sample is decoded
   a_left_load: assert property (@(posedge clock) disable iff (reset)
      (left_ff > $past(left_ff)) |->
         $past(advance && !in_start_ff && hdr_ff == HDR_SAMPLE_HI))
      else $error("samples_left grew outside header");

endmodule
